/* hdl/pee_pkg.sv */
// ----------------------------------------------------------------------------
// pee_pkg - shared definitions for the prefix expression evaluator
// Stack geometry, character codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DIV  = 2'd2,
    S_FIN  = 2'd3
  } state_t;

endpackage

/* hdl/prefix_expression_evaluator_core.sv */
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_core - stack-based prefix expression evaluator
//
// Input stream: one character word per transfer, last character of the
// expression first. in_tdata carries the character, in_tlast marks the
// first character of the expression and closes it. Digits push 0..9,
// '*', '/', '+', '-' pop top a then b and push a op b; other bytes are
// ignored. Arithmetic wraps at 32 bits, division truncates toward zero.
// Output stream: one word per expression, value in out_tdata and status
// in out_tuser (0 ok, 1 underflow, 2 overflow, 3 divide by zero); value is
// 0 whenever status is not ok. Only the first error is kept.
// Timing: the stack top lives in a register, the rest in a RAM with
// registered read data. A digit or ignored byte is handled on acceptance;
// an operator does a RAM read, then executes; a division adds the 32
// bit-steps of the iterative divider, the sign fix and the result handoff.
// A closing word then loads the output register.
// Reset clears the sequencer state, stack count, status and output valid; no RAM clear.
// If the output register is still full when an expression closes, the
// core waits with in_tready low until the receiver takes the word.
// ----------------------------------------------------------------------------
module prefix_expression_evaluator_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] token
  input  logic        in_tlast,   // is_last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int W = pee_pkg::VALUE_WIDTH;

  pee_pkg::state_t            state_r, state_nxt;
  logic [pee_pkg::CNT_W-1:0]  count_r, count_nxt;
  pee_pkg::status_t           err_r, err_nxt;
  logic [W-1:0]               top_r, top_nxt;
  pee_pkg::op_t               op_r, op_nxt;
  logic                       last_r, last_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [31:0]                out_value_r, out_value_nxt;
  pee_pkg::status_t           out_status_r, out_status_nxt;

  // stack RAM holds entries below the top register
  logic                       ram_we;
  logic [pee_pkg::ADDR_W-1:0] ram_waddr;
  logic [pee_pkg::ADDR_W-1:0] ram_raddr;
  logic [W-1:0]               ram_rdata;

  logic                       div_start;
  logic                       div_done;
  logic [W-1:0]               div_q;

  logic                       in_acc;
  logic                       tok_digit;
  logic                       tok_op;
  pee_pkg::op_t               tok_kind;
  logic                       cnt_full;
  logic                       out_free;
  logic [W-1:0]               prod;
  logic [W-1:0]               sum;
  logic [W-1:0]               dif;

  assign in_tready = (state_r == pee_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cnt_full  = (count_r == pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH));
  assign out_free  = !out_valid_r || out_tready;

  assign tok_digit = (in_tdata >= pee_pkg::CH_ZERO) && (in_tdata <= pee_pkg::CH_NINE);

  always_comb begin
    tok_op   = 1'b1;
    tok_kind = pee_pkg::OP_MUL;
    case (in_tdata)
      pee_pkg::CH_MUL: tok_kind = pee_pkg::OP_MUL;
      pee_pkg::CH_DIV: tok_kind = pee_pkg::OP_DIV;
      pee_pkg::CH_ADD: tok_kind = pee_pkg::OP_ADD;
      pee_pkg::CH_SUB: tok_kind = pee_pkg::OP_SUB;
      default:         tok_op   = 1'b0;
    endcase
  end

  // a = top register, b = entry just below it (RAM read data)
  assign prod = top_r * ram_rdata;
  assign sum  = top_r + ram_rdata;
  assign dif  = top_r - ram_rdata;

  // pushes write the old top at count-1; pops read count-2. A write
  // always lands before any read that could see it.
  assign ram_waddr = pee_pkg::ADDR_W'(count_r - pee_pkg::CNT_W'(1));
  assign ram_raddr = pee_pkg::ADDR_W'(count_r - pee_pkg::CNT_W'(2));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    top_nxt        = top_r;
    op_nxt         = op_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    div_start      = 1'b0;

    case (state_r)
      pee_pkg::S_IDLE: begin
        if (in_acc) begin
          last_nxt  = in_tlast;
          op_nxt    = tok_kind;
          state_nxt = in_tlast ? pee_pkg::S_FIN : pee_pkg::S_IDLE;
          if (tok_digit) begin
            if (cnt_full) begin
              if (err_r == pee_pkg::ST_OK) err_nxt = pee_pkg::ST_OVER;
            end else begin
              ram_we    = (count_r != '0);
              top_nxt   = W'(in_tdata - pee_pkg::CH_ZERO);
              count_nxt = count_r + 1'b1;
            end
          end else if (tok_op) begin
            if (count_r < pee_pkg::CNT_W'(2)) begin
              if (err_r == pee_pkg::ST_OK) err_nxt = pee_pkg::ST_UNDER;
            end else begin
              state_nxt = pee_pkg::S_EXEC;
            end
          end
        end
      end

      pee_pkg::S_EXEC: begin
        count_nxt = count_r - 1'b1;
        state_nxt = last_r ? pee_pkg::S_FIN : pee_pkg::S_IDLE;
        case (op_r)
          pee_pkg::OP_MUL: top_nxt = prod;
          pee_pkg::OP_ADD: top_nxt = sum;
          pee_pkg::OP_SUB: top_nxt = dif;
          pee_pkg::OP_DIV: begin
            if (ram_rdata == '0) begin
              if (err_r == pee_pkg::ST_OK) err_nxt = pee_pkg::ST_DIVZ;
              top_nxt = '0;
            end else begin
              div_start = 1'b1;
              state_nxt = pee_pkg::S_DIV;
            end
          end
          default: top_nxt = top_r;
        endcase
      end

      pee_pkg::S_DIV: begin
        if (div_done) begin
          top_nxt   = div_q;
          state_nxt = last_r ? pee_pkg::S_FIN : pee_pkg::S_IDLE;
        end
      end

      pee_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (err_r != pee_pkg::ST_OK) begin
            out_status_nxt = err_r;
            out_value_nxt  = '0;
          end else if (count_r == '0) begin
            out_status_nxt = pee_pkg::ST_UNDER;
            out_value_nxt  = '0;
          end else begin
            out_status_nxt = pee_pkg::ST_OK;
            out_value_nxt  = 32'(signed'(top_r));
          end
          count_nxt = '0;
          err_nxt   = pee_pkg::ST_OK;
          state_nxt = pee_pkg::S_IDLE;
        end
      end

      default: state_nxt = pee_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pee_pkg::S_IDLE;
      count_r     <= '0;
      err_r       <= pee_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r        <= top_nxt;
    op_r         <= op_nxt;
    last_r       <= last_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  pee_ram #(
    .WIDTH (W),
    .DEPTH (pee_pkg::STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (top_r),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  pee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (top_r),
    .divisor  (ram_rdata),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // stack count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  // closing an expression loads the output and empties the stack
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pee_pkg::S_FIN && out_free) |=>
      (out_valid_r && count_r == '0 && err_r == pee_pkg::ST_OK))
    else $error("close did not load output or clear stack");

  // a failed expression reports a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != pee_pkg::ST_OK) |-> (out_value_r == '0))
    else $error("nonzero value with error status");

  // divider start moves the sequencer into the divide wait
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == pee_pkg::S_DIV))
    else $error("divider started outside divide wait");

endmodule

/* hdl/pee_ram.sv */
// ----------------------------------------------------------------------------
// pee_ram - generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/pee_div.sv */
// ----------------------------------------------------------------------------
// pee_div - iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, then a
// sign fix step. Truncates toward zero. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module pee_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [pee_pkg::VALUE_WIDTH-1:0] dividend,
  input  logic [pee_pkg::VALUE_WIDTH-1:0] divisor,
  output logic                            done,
  output logic [pee_pkg::VALUE_WIDTH-1:0] quotient
);

  localparam int W   = pee_pkg::VALUE_WIDTH;
  localparam int CW  = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          fix_r, fix_nxt;
  logic          done_r, done_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  mb_r, mb_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  // remainder stays below the divisor, so it fits in W bits
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, mb_r};

  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    mb_nxt   = mb_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
      quo_nxt  = dividend[W-1] ? (~dividend + 1'b1) : dividend;
      mb_nxt   = divisor[W-1] ? (~divisor + 1'b1) : divisor;
      rem_nxt  = '0;
      cnt_nxt  = CW'(W - 1);
    end else if (busy_r) begin
      if (diff[W]) begin
        rem_nxt = rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      q_nxt    = neg_r ? (~quo_r + 1'b1) : quo_r;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    mb_r  <= mb_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
